FILE: hw/rtl/mmt_pkg.sv
// Shared types and constants for the moment matrix transfer block.
package mmt_pkg;

  localparam int DIM = 7;
  localparam int MAT_DEPTH = DIM * DIM;
  localparam int ADDR_W = $clog2(MAT_DEPTH);
  localparam int IDX_W = 3;
  // A dot product of DIM truncated Q16.16 products needs this many bits.
  localparam int ACC_W = 50;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  localparam logic signed [ACC_W-1:0] SAT_MAX = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN = {{(ACC_W-31){1'b1}}, 31'd0};

  typedef enum logic [1:0] {
    KIND_WR_T = 2'd0,
    KIND_WR_S = 2'd1,
    KIND_WR_M = 2'd2,
    KIND_ADV  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VEC,
    ST_PROD,
    ST_MOM,
    ST_EMIT_V,
    ST_EMIT_S
  } state_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic               target;
    logic [IDX_W-1:0]   out_row;
    logic [IDX_W-1:0]   out_col;
    logic signed [31:0] out_value;
    logic               last;
  } res_t;

  // Saturate a wide sum to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] s);
    if (s > SAT_MAX) begin
      return 32'sh7FFF_FFFF;
    end else if (s < SAT_MIN) begin
      return 32'sh8000_0000;
    end else begin
      return s[31:0];
    end
  endfunction

endpackage

FILE: hw/rtl/moment_matrix_transfer.sv
// Top level of the moment matrix transfer block.
// After reset the block is busy while a sweep loads T and S with identity and clears
// m. An advance runs three phases of multiply-accumulate on one shared 32x32
// multiplier, one product per cycle from the state memories while a dot product is
// issuing, through a two-stage read/multiply pipe. Each dot product issues DIM
// products and then waits for its sum to leave the pipe before the next one starts.
// The block then emits DIM + DIM*DIM results, one per cycle, the first in the cycle
// after the emit phase begins. busy goes high the cycle after an advance is accepted
// and drops in the cycle that carries the last result. The receiver cannot stall the
// result stream.
module moment_matrix_transfer (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  mmt_pkg::req_t      req,
  output logic               strobe,
  output mmt_pkg::res_t      res
);

  localparam int AW = mmt_pkg::ADDR_W;
  localparam int IW = mmt_pkg::IDX_W;

  // Memories: T and S are loaded with identity and m is cleared by a sweep after reset.
  logic [31:0] t_mem [mmt_pkg::MAT_DEPTH];
  logic [31:0] s_mem [mmt_pkg::MAT_DEPTH];
  logic [31:0] p_mem [mmt_pkg::MAT_DEPTH];
  logic [31:0] m_mem [mmt_pkg::DIM];
  logic [31:0] mnew  [mmt_pkg::DIM];

  mmt_pkg::state_t state, state_next;

  logic          init;
  logic [IW-1:0] ci, cj, ck;     // loop counters
  logic [AW-1:0] init_addr;
  logic          last_k;

  // Pipe: stage 1 read data valid, stage 2 product valid.
  logic          v1, v2;
  logic          l1, l2;
  logic [IW-1:0] i1, j1, i2, j2;
  logic [31:0]   ra, rb;
  logic signed [63:0] prod;
  logic signed [mmt_pkg::ACC_W-1:0] acc;
  logic signed [mmt_pkg::ACC_W-1:0] acc_sum;
  mmt_pkg::state_t ph1, ph2;

  logic          emit_last;

  function automatic logic [AW-1:0] addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    logic [AW+IW-1:0] a;
    a = (AW+IW)'(r) * (AW+IW)'(mmt_pkg::DIM) + (AW+IW)'(c);
    return a[AW-1:0];
  endfunction

  assign busy = init || (state != mmt_pkg::ST_IDLE);
  assign last_k = (ck == IW'(mmt_pkg::DIM - 1));

  // Next state: a phase ends once its final accumulate has left the pipe.
  always_comb begin
    state_next = state;
    unique case (state)
      mmt_pkg::ST_IDLE: begin
        if (start && !busy && req.kind == mmt_pkg::KIND_ADV) begin
          state_next = mmt_pkg::ST_VEC;
        end
      end
      mmt_pkg::ST_VEC: begin
        if (v2 && l2 && ph2 == mmt_pkg::ST_VEC && i2 == IW'(mmt_pkg::DIM - 1)) begin
          state_next = mmt_pkg::ST_PROD;
        end
      end
      mmt_pkg::ST_PROD: begin
        if (v2 && l2 && ph2 == mmt_pkg::ST_PROD && i2 == IW'(mmt_pkg::DIM - 1) &&
            j2 == IW'(mmt_pkg::DIM - 1)) begin
          state_next = mmt_pkg::ST_MOM;
        end
      end
      mmt_pkg::ST_MOM: begin
        if (v2 && l2 && ph2 == mmt_pkg::ST_MOM && i2 == IW'(mmt_pkg::DIM - 1) &&
            j2 == IW'(mmt_pkg::DIM - 1)) begin
          state_next = mmt_pkg::ST_EMIT_V;
        end
      end
      mmt_pkg::ST_EMIT_V: begin
        if (ci == IW'(mmt_pkg::DIM - 1)) begin
          state_next = mmt_pkg::ST_EMIT_S;
        end
      end
      mmt_pkg::ST_EMIT_S: begin
        if (emit_last) begin
          state_next = mmt_pkg::ST_IDLE;
        end
      end
      default: state_next = mmt_pkg::ST_IDLE;
    endcase
  end

  assign emit_last = (state == mmt_pkg::ST_EMIT_S) && ci == IW'(mmt_pkg::DIM - 1) &&
                     cj == IW'(mmt_pkg::DIM - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Counters and issue of one product per cycle. A dot product issues DIM reads,
  // then waits for its accumulate to finish before the next one starts.
  logic issuing;
  logic wait_acc;
  always_ff @(posedge clk) begin
    if (rst) begin
      init      <= 1'b1;
      init_addr <= '0;
      ci        <= '0;
      cj        <= '0;
      ck        <= '0;
      wait_acc  <= 1'b0;
    end else begin
      if (init) begin
        if (init_addr == AW'(mmt_pkg::MAT_DEPTH - 1)) begin
          init <= 1'b0;
        end
        init_addr <= init_addr + 1'b1;
      end
      if (state != state_next) begin
        ci <= '0;
        cj <= '0;
        ck <= '0;
        wait_acc <= 1'b0;
      end else if (issuing) begin
        if (last_k) begin
          ck <= '0;
          wait_acc <= 1'b1;
          if (state == mmt_pkg::ST_VEC || cj == IW'(mmt_pkg::DIM - 1)) begin
            cj <= '0;
            ci <= ci + 1'b1;
          end else begin
            cj <= cj + 1'b1;
          end
        end else begin
          ck <= ck + 1'b1;
        end
      end else if (wait_acc && v2 && l2) begin
        wait_acc <= 1'b0;
      end else if (state == mmt_pkg::ST_EMIT_V || state == mmt_pkg::ST_EMIT_S) begin
        if (ci == IW'(mmt_pkg::DIM - 1) && state == mmt_pkg::ST_EMIT_V) begin
          ci <= '0;
        end else if (state == mmt_pkg::ST_EMIT_V) begin
          ci <= ci + 1'b1;
        end else if (cj == IW'(mmt_pkg::DIM - 1)) begin
          cj <= '0;
          ci <= ci + 1'b1;
        end else begin
          cj <= cj + 1'b1;
        end
      end
    end
  end

  assign issuing = !wait_acc && (state == mmt_pkg::ST_VEC || state == mmt_pkg::ST_PROD ||
                                 state == mmt_pkg::ST_MOM) && state == state_next;

  // Memory writes and registered reads.
  logic [31:0] rd_s;
  always_ff @(posedge clk) begin
    if (init) begin
      t_mem[init_addr] <= (init_addr % AW'(mmt_pkg::DIM + 1) == '0) ? mmt_pkg::ONE_Q16 : '0;
      s_mem[init_addr] <= (init_addr % AW'(mmt_pkg::DIM + 1) == '0) ? mmt_pkg::ONE_Q16 : '0;
      if (init_addr < AW'(mmt_pkg::DIM)) begin
        m_mem[init_addr[IW-1:0]] <= '0;
      end
    end else if (start && !busy) begin
      if (req.kind == mmt_pkg::KIND_WR_T && req.row < IW'(mmt_pkg::DIM) &&
          req.col < IW'(mmt_pkg::DIM)) begin
        t_mem[addr(req.row, req.col)] <= req.value;
      end
      if (req.kind == mmt_pkg::KIND_WR_S && req.row < IW'(mmt_pkg::DIM) &&
          req.col < IW'(mmt_pkg::DIM)) begin
        s_mem[addr(req.row, req.col)] <= req.value;
      end
      if (req.kind == mmt_pkg::KIND_WR_M && req.row < IW'(mmt_pkg::DIM)) begin
        m_mem[req.row] <= req.value;
      end
    end
    if (v2 && l2) begin
      unique case (ph2)
        mmt_pkg::ST_VEC:  mnew[i2] <= mmt_pkg::sat32(acc_sum);
        mmt_pkg::ST_PROD: p_mem[addr(i2, j2)] <= mmt_pkg::sat32(acc_sum);
        mmt_pkg::ST_MOM:  s_mem[addr(i2, j2)] <= mmt_pkg::sat32(acc_sum);
        default: ;
      endcase
    end
    if (state == mmt_pkg::ST_PROD && state_next == mmt_pkg::ST_MOM) begin
      for (int n = 0; n < mmt_pkg::DIM; n++) begin
        m_mem[n] <= mnew[n];
      end
    end
    // Operand reads for the pipe.
    unique case (state)
      mmt_pkg::ST_VEC: begin
        ra <= t_mem[addr(ci, ck)];
        rb <= m_mem[ck];
      end
      mmt_pkg::ST_PROD: begin
        ra <= t_mem[addr(ci, ck)];
        rb <= s_mem[addr(ck, cj)];
      end
      mmt_pkg::ST_MOM: begin
        ra <= p_mem[addr(ci, ck)];
        rb <= t_mem[addr(cj, ck)];
      end
      default: begin
        ra <= '0;
        rb <= '0;
      end
    endcase
    rd_s <= s_mem[addr(ci, cj)];
    i1 <= ci;
    j1 <= cj;
    l1 <= last_k;
    ph1 <= state;
    i2 <= i1;
    j2 <= j1;
    l2 <= l1;
    ph2 <= ph1;
    prod <= $signed(ra) * $signed(rb);
  end

  assign acc_sum = acc + mmt_pkg::ACC_W'(prod >>> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      acc <= '0;
    end else begin
      v1 <= issuing;
      v2 <= v1;
      if (v2) begin
        acc <= l2 ? '0 : acc_sum;
      end
    end
  end

  // Result stage: vector entries come from the registered read of m_mem, matrix
  // entries from the registered read of s_mem.
  logic          e_v, e_s;
  logic [IW-1:0] e_r, e_c;
  logic          e_last;
  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
      e_s <= 1'b0;
    end else begin
      e_v <= (state == mmt_pkg::ST_EMIT_V);
      e_s <= (state == mmt_pkg::ST_EMIT_S);
    end
    e_r    <= ci;
    e_c    <= cj;
    e_last <= emit_last;
  end

  logic [31:0] vec_q;
  always_ff @(posedge clk) begin
    vec_q <= m_mem[ci];
  end

  assign strobe = e_v || e_s;
  always_comb begin
    res.target    = e_s;
    res.out_row   = e_r;
    res.out_col   = e_s ? e_c : '0;
    res.out_value = e_s ? rd_s : vec_q;
    res.last      = e_s && e_last;
  end

  a_one_kind: assert property (@(posedge clk) disable iff (rst) !(e_v && e_s))
    else $error("vector and matrix results at once");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && res.last) |=> !strobe)
    else $error("result after last");
  a_no_issue_idle: assert property (@(posedge clk) disable iff (rst)
    (state == mmt_pkg::ST_IDLE) |-> !issuing)
    else $error("product issued while idle");
  a_busy_emit: assert property (@(posedge clk) disable iff (rst)
    (state == mmt_pkg::ST_EMIT_S) |-> busy)
    else $error("emit without busy");

endmodule
